// ----- rtl/deq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared types and constants for the ring-buffer deque.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEQ_DEPTH_DEFAULT = 16;
   localparam int WORD_W            = 32;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic commit;     // apply the accepted operation to the queue state
      logic load_out;   // move the pending result into the output register
   } deq_cmd_type;

endpackage

// ----- rtl/deq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque controller
// Sequences one operation at a time and owns the channel handshakes.
// ----------------------------------------------------------------------------
module deq_ctrl
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output deq_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.commit = req_valid;
            if (req_valid) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // The pending result waits here until the output register drains.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/deq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque datapath
// Ring-buffer store, front index, entry count and the result registers.
// ----------------------------------------------------------------------------
module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  deq_cmd_type              cmd,
   input  logic [1:0]               req_opcode,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic signed [WORD_W-1:0] rsp_popped_value,
   output logic [1:0]               rsp_status,
   output logic                     rsp_now_empty,
   output logic                     rsp_now_full
);

   localparam int           AW      = $clog2(DEPTH);
   localparam logic [AW:0]  DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   logic [AW-1:0] front_ff, front_in;
   logic [AW:0]   count_ff, count_in;

   status_type    pend_status_ff, pend_status_in;
   logic          pend_read_ff, pend_read_in;
   logic          pend_neg_ff, pend_neg_in;
   logic          pend_empty_ff, pend_full_ff;

   logic [WORD_W-1:0] out_value_ff;
   status_type        out_status_ff;
   logic              out_empty_ff, out_full_ff;

   logic          is_empty, is_full;
   logic [AW-1:0] prev_front, next_front, back_slot, last_slot, slot;
   logic [AW:0]   back_sum, last_sum;
   logic          wr_en, rd_en;
   opcode_type    op;

   assign op       = opcode_type'(req_opcode);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == DEPTH_W);

   assign prev_front = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign next_front = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;

   // Both sums stay below twice the depth, so one conditional subtract wraps them.
   assign back_sum  = {1'b0, front_ff} + count_ff;
   assign last_sum  = {1'b0, front_ff} + count_ff - 1'b1;
   assign back_slot = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : AW'(back_sum);
   assign last_slot = (last_sum >= DEPTH_W) ? AW'(last_sum - DEPTH_W) : AW'(last_sum);

   always_comb begin
      front_in       = front_ff;
      count_in       = count_ff;
      slot           = front_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      pend_status_in = ST_DONE;
      pend_read_in   = 1'b0;
      pend_neg_in    = 1'b0;
      unique case (op)
         OP_PUSH_FRONT: begin
            if (is_full) begin
               pend_status_in = ST_FULL;
            end else begin
               slot     = prev_front;
               front_in = prev_front;
               count_in = count_ff + 1'b1;
               wr_en    = cmd.commit;
            end
         end
         OP_PUSH_BACK: begin
            if (is_full) begin
               pend_status_in = ST_FULL;
            end else begin
               slot     = back_slot;
               count_in = count_ff + 1'b1;
               wr_en    = cmd.commit;
            end
         end
         OP_POP_FRONT: begin
            if (is_empty) begin
               pend_status_in = ST_EMPTY;
               pend_neg_in    = 1'b1;
            end else begin
               slot         = front_ff;
               front_in     = next_front;
               count_in     = count_ff - 1'b1;
               rd_en        = cmd.commit;
               pend_read_in = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (is_empty) begin
               pend_status_in = ST_EMPTY;
               pend_neg_in    = 1'b1;
            end else begin
               slot         = last_slot;
               count_in     = count_ff - 1'b1;
               rd_en        = cmd.commit;
               pend_read_in = 1'b1;
            end
         end
         default: begin
            pend_status_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot] <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         pend_status_ff <= pend_status_in;
         pend_read_ff   <= pend_read_in;
         pend_neg_ff    <= pend_neg_in;
         pend_empty_ff  <= (count_in == '0);
         pend_full_ff   <= (count_in == DEPTH_W);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (pend_read_ff) begin
            out_value_ff <= rd_data_ff;
         end else begin
            out_value_ff <= {WORD_W{pend_neg_ff}};
         end
         out_status_ff <= pend_status_ff;
         out_empty_ff  <= pend_empty_ff;
         out_full_ff   <= pend_full_ff;
      end
   end

   assign rsp_popped_value = $signed(out_value_ff);
   assign rsp_status       = out_status_ff;
   assign rsp_now_empty    = out_empty_ff;
   assign rsp_now_full     = out_full_ff;

endmodule

// ----- rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring buffer of signed words with push and pop at either end.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  req_      in         opcode, push_value
//  rsp_      out        popped_value, status, now_empty, now_full
//
//  In S_IDLE the accepted beat updates the indices and issues the store write or
//  read; S_FINISH then loads the result register.
//  A result waiting on rsp_ready holds S_FINISH, so no new beat is taken.
//  Synchronous reset empties the queue at once; the store itself is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = DEQ_DEPTH_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_opcode,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_popped_value,
   output logic [1:0]               rsp_status,
   output logic                     rsp_now_empty,
   output logic                     rsp_now_full
);

   deq_cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_opcode       (req_opcode),
      .req_push_value   (req_push_value),
      .rsp_popped_value (rsp_popped_value),
      .rsp_status       (rsp_status),
      .rsp_now_empty    (rsp_now_empty),
      .rsp_now_full     (rsp_now_full)
   );

endmodule

// ----- rtl/deq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque port checker
// Checks result beats and handshake behavior seen on the top-level ports.
// ----------------------------------------------------------------------------
module deq_checker
   import deq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [WORD_W-1:0] rsp_popped_value,
   input logic [1:0]               rsp_status,
   input logic                     rsp_now_empty,
   input logic                     rsp_now_full
);

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_value)
         && $stable(rsp_status) && $stable(rsp_now_empty) && $stable(rsp_now_full))
      else $error("result beat changed while stalled");

   // An operation is in flight, with req_ready low, in the cycle after its beat.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted during an operation");

   // A pop on an empty queue returns all ones and leaves it empty.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_popped_value == -32'sd1)
         && rsp_now_empty && !rsp_now_full)
      else $error("bad empty-pop result");

   // A dropped push leaves the queue full and returns zero.
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (rsp_popped_value == '0)
         && rsp_now_full && !rsp_now_empty)
      else $error("bad full-push result");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_popped_value (rsp_popped_value),
   .rsp_status       (rsp_status),
   .rsp_now_empty    (rsp_now_empty),
   .rsp_now_full     (rsp_now_full)
);
